// ----- rtl/bmsd_pkg.sv -----
// shared types, register codes and constants of the button matrix scanner
package bmsd_pkg;

  localparam int LEVEL_W    = 6;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 8;
  localparam int LINE_OUT_W = 4;
  localparam int SIDE_W     = 2;
  localparam int ROW_W      = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CNT_W-1:0]  CNT_MAX = '1;

  // lines 0..4 are back, 5..9 front, the rest cabin
  localparam logic [LINE_OUT_W-1:0] BACK_END  = 4'd5;
  localparam logic [LINE_OUT_W-1:0] FRONT_END = 4'd10;

  localparam logic [CNT_W-1:0]  SAMPLES_RST = 8'd50;
  localparam logic [CNT_W-1:0]  EMIT_RST    = 8'd40;
  localparam logic [TIME_W-1:0] HOLDOFF_RST = 32'd500000;
  localparam logic              LEVEL_RST   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLES = 2'd0,
    CFG_EMIT    = 2'd1,
    CFG_HOLDOFF = 2'd2,
    CFG_LEVEL   = 2'd3
  } cfg_idx_t;

  typedef enum logic [SIDE_W-1:0] {
    SIDE_BACK  = 2'd0,
    SIDE_FRONT = 2'd1,
    SIDE_CABIN = 2'd2
  } side_t;

  typedef struct packed {
    logic [CNT_W-1:0]  samples_per_row;
    logic [CNT_W-1:0]  count_to_emit;
    logic [TIME_W-1:0] holdoff_us;
    logic              active_level;
  } cfg_t;

  typedef struct packed {
    logic [LINE_OUT_W-1:0] drive_line;
    logic                  row_complete;
    logic [LEVEL_W-1:0]    event_mask;
    logic [LINE_OUT_W-1:0] event_line;
    logic [SIDE_W-1:0]     event_side;
    logic [ROW_W-1:0]      event_row;
  } res_t;

  typedef struct packed {
    side_t            side;
    logic [ROW_W-1:0] row;
  } loc_t;

  function automatic loc_t locate(input logic [LINE_OUT_W-1:0] line);
    loc_t loc;
    if (line < BACK_END) begin
      loc.side = SIDE_BACK;
      loc.row  = ROW_W'(line + 4'd1);
    end else if (line < FRONT_END) begin
      loc.side = SIDE_FRONT;
      loc.row  = ROW_W'(line - 4'd4);
    end else begin
      loc.side = SIDE_CABIN;
      loc.row  = 3'd1;
    end
    return loc;
  endfunction

endpackage

// ----- rtl/bmsd_cfg_regs.sv -----
// configuration register file of the button matrix scanner
module bmsd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bmsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmsd_pkg::TIME_W-1:0]     cfg_data,
  output bmsd_pkg::cfg_t                  cfg
);
  import bmsd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SAMPLES: cfg_nxt.samples_per_row = cfg_data[CNT_W-1:0];
        CFG_EMIT:    cfg_nxt.count_to_emit   = cfg_data[CNT_W-1:0];
        CFG_HOLDOFF: cfg_nxt.holdoff_us      = cfg_data;
        CFG_LEVEL:   cfg_nxt.active_level    = cfg_data[0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_row <= SAMPLES_RST;
      cfg_r.count_to_emit   <= EMIT_RST;
      cfg_r.holdoff_us      <= HOLDOFF_RST;
      cfg_r.active_level    <= LEVEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/bmsd_time_store.sv -----
// per-button last report time memory, one row per line, with row valid bits
module bmsd_time_store #(
  parameter int LINES = 11,
  parameter int NCOL  = 6
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [$clog2(LINES)-1:0]                 rd_line,
  output logic [NCOL*bmsd_pkg::TIME_W-1:0]         rd_row,
  input  logic                                     wr_en,
  input  logic [$clog2(LINES)-1:0]                 wr_line,
  input  logic [NCOL*bmsd_pkg::TIME_W-1:0]         wr_row
);
  import bmsd_pkg::*;

  localparam int ROW_BITS = NCOL * TIME_W;

  logic [ROW_BITS-1:0] mem [LINES];
  logic [LINES-1:0]    row_vld_r;
  logic [ROW_BITS-1:0] rd_row_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_line] <= wr_row;
    end
    rd_row_r <= mem[rd_line];
  end

  // a row never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_line] <= 1'b1;
      end
      rd_vld_r <= row_vld_r[rd_line];
    end
  end

  assign rd_row = rd_vld_r ? rd_row_r : '0;

endmodule

// ----- rtl/bmsd_scan.sv -----
// line scan state, per-column hit counting and press qualification
module bmsd_scan #(
  parameter int LINES = 11,
  parameter int NCOL  = 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  fire,
  input  logic [bmsd_pkg::LEVEL_W-1:0]          levels,
  input  logic [bmsd_pkg::TIME_W-1:0]           now,
  input  bmsd_pkg::cfg_t                        cfg,
  input  logic [NCOL*bmsd_pkg::TIME_W-1:0]      stamps,
  output bmsd_pkg::res_t                        res,
  output logic [$clog2(LINES)-1:0]              rd_line,
  output logic                                  wr_en,
  output logic [$clog2(LINES)-1:0]              wr_line,
  output logic [NCOL*bmsd_pkg::TIME_W-1:0]      wr_row
);
  import bmsd_pkg::*;

  localparam int LW = $clog2(LINES);
  localparam logic [LW-1:0] LAST_LINE = LW'(LINES - 1);

  logic [LW-1:0]               line_r, line_nxt, line_adv;
  logic [CNT_W-1:0]            count_r, count_nxt, count_inc;
  logic [NCOL-1:0][CNT_W-1:0]  hits_r, hits_nxt, hits_inc;
  logic [LEVEL_W-1:0]          active;
  logic [LEVEL_W-1:0]          mask;
  logic [TIME_W-1:0]           stamp;
  logic [TIME_W-1:0]           elapsed;
  logic                        done;
  loc_t                        loc;

  assign active    = cfg.active_level ? levels : ~levels;
  assign count_inc = count_r + CNT_W'(count_r != CNT_MAX);
  assign done      = count_inc >= cfg.samples_per_row;
  assign line_adv  = (line_r == LAST_LINE) ? '0 : line_r + LW'(1);
  assign line_nxt  = (fire && done) ? line_adv : line_r;
  assign loc       = locate(LINE_OUT_W'(line_r));

  always_comb begin
    mask   = '0;
    wr_row = stamps;
    stamp  = '0;
    elapsed = '0;
    for (int c = 0; c < NCOL; c++) begin
      // counts saturate
      hits_inc[c] = hits_r[c] + CNT_W'(active[c] && (hits_r[c] != CNT_MAX));
      stamp       = stamps[c*TIME_W +: TIME_W];
      elapsed     = now - stamp;
      mask[c]     = done && (hits_inc[c] >= cfg.count_to_emit)
                    && (elapsed > cfg.holdoff_us);
      if (mask[c]) begin
        wr_row[c*TIME_W +: TIME_W] = now;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    hits_nxt  = hits_r;
    if (fire) begin
      count_nxt = done ? '0 : count_inc;
      hits_nxt  = done ? '0 : hits_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r  <= '0;
      count_r <= '0;
      hits_r  <= '0;
    end else begin
      line_r  <= line_nxt;
      count_r <= count_nxt;
      hits_r  <= hits_nxt;
    end
  end

  // the stamp row is fetched for the line that will be scanned next cycle
  assign rd_line = line_nxt;
  assign wr_en   = fire && done;
  assign wr_line = line_r;

  always_comb begin
    res.drive_line   = LINE_OUT_W'(line_nxt);
    res.row_complete = done;
    res.event_mask   = mask;
    res.event_line   = done ? LINE_OUT_W'(line_r) : '0;
    res.event_side   = done ? loc.side : SIDE_BACK;
    res.event_row    = done ? loc.row : 3'd1;
  end

endmodule

// ----- rtl/button_matrix_scan_debounce_core.sv -----
// top level of the button matrix scanner with per-button debounce
//
//  channel  handshake              payload
//  in       in_valid / in_ready    in_col_levels, in_now_us
//  out      out_valid / out_ready  out_drive_line, out_row_complete, out_event_mask,
//                                  out_event_line, out_event_side, out_event_row
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle while the output is not stalled; an item is held in the input
// register, and its result is then registered in the output register, which raises out_valid
// the last report time row for the next line is read ahead from memory
// reset clears scan state and row valid bits at once; no clearing pass
// a stalled output holds the input register, which then drops in_ready
module button_matrix_scan_debounce_core #(
  parameter int LINES   = 11,
  parameter int COLUMNS = 6
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [bmsd_pkg::LEVEL_W-1:0]           in_col_levels,
  input  logic [bmsd_pkg::TIME_W-1:0]            in_now_us,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [bmsd_pkg::LINE_OUT_W-1:0]        out_drive_line,
  output logic                                   out_row_complete,
  output logic [bmsd_pkg::LEVEL_W-1:0]           out_event_mask,
  output logic [bmsd_pkg::LINE_OUT_W-1:0]        out_event_line,
  output logic [bmsd_pkg::SIDE_W-1:0]            out_event_side,
  output logic [bmsd_pkg::ROW_W-1:0]             out_event_row,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bmsd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bmsd_pkg::TIME_W-1:0]            cfg_data
);
  import bmsd_pkg::*;

  // columns past the level input never report
  localparam int NCOL = (COLUMNS < LEVEL_W) ? COLUMNS : LEVEL_W;
  localparam int LW   = $clog2(LINES);

  cfg_t                     cfg;
  res_t                     res;
  res_t                     res_r;
  logic                     in_vld_r, in_vld_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic [LEVEL_W-1:0]       levels_r;
  logic [TIME_W-1:0]        now_r;
  logic                     fire;
  logic                     in_take;
  logic [LW-1:0]            rd_line;
  logic                     wr_en;
  logic [LW-1:0]            wr_line;
  logic [NCOL*TIME_W-1:0]   wr_row;
  logic [NCOL*TIME_W-1:0]   stamps;

  bmsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bmsd_time_store #(.LINES(LINES), .NCOL(NCOL)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_line (rd_line),
    .rd_row  (stamps),
    .wr_en   (wr_en),
    .wr_line (wr_line),
    .wr_row  (wr_row)
  );

  bmsd_scan #(.LINES(LINES), .NCOL(NCOL)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .levels  (levels_r),
    .now     (now_r),
    .cfg     (cfg),
    .stamps  (stamps),
    .res     (res),
    .rd_line (rd_line),
    .wr_en   (wr_en),
    .wr_line (wr_line),
    .wr_row  (wr_row)
  );

  assign fire        = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready    = !in_vld_r || fire;
  assign in_take     = in_valid && in_ready;
  assign in_vld_nxt  = in_take || (in_vld_r && !fire);
  assign out_vld_nxt = fire || (out_vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      levels_r <= in_col_levels;
      now_r    <= in_now_us;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_drive_line   = res_r.drive_line;
  assign out_row_complete = res_r.row_complete;
  assign out_event_mask   = res_r.event_mask;
  assign out_event_line   = res_r.event_line;
  assign out_event_side   = res_r.event_side;
  assign out_event_row    = res_r.event_row;

endmodule
